// ===== hdl/flvp_pkg.sv =====
// Shared types and constants for the FLV tag header parser.
package flvp_pkg;

  localparam int unsigned OUT_DATA_W = 160;

  localparam logic [4:0] TYPE_SCRIPT = 5'd18;
  localparam logic [4:0] TYPE_VIDEO  = 5'd9;
  localparam logic [4:0] TYPE_AUDIO  = 5'd8;
  localparam logic [7:0] TYPE_MASK   = 8'h1F;

  localparam logic [23:0] HDR_LAST_IDX   = 24'd8;
  localparam logic [23:0] HDR_VER_IDX    = 24'd3;
  localparam logic [23:0] HDR_FLAGS_IDX  = 24'd4;
  localparam logic [23:0] TAG_PREV_IDX   = 24'd3;
  localparam logic [23:0] TAG_TYPE_IDX   = 24'd4;
  localparam logic [23:0] TAG_SIZE_IDX   = 24'd7;
  localparam logic [23:0] TAG_STAMP_IDX  = 24'd10;
  localparam logic [23:0] TAG_EXT_IDX    = 24'd11;
  localparam logic [23:0] TAG_LAST_IDX   = 24'd14;

  localparam logic REC_FILE_HDR = 1'b0;
  localparam logic REC_TAG      = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_TAGHDR  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic        record_kind;
    logic [4:0]  type_code;
    logic        filter_bit;
    logic [23:0] payload_len;
    logic [23:0] time_stamp;
    logic [7:0]  time_stamp_ext;
    logic [23:0] stream_ident;
    logic [31:0] prev_tag_size;
    logic [31:0] position;
    logic [7:0]  version;
    logic        has_video;
    logic        has_audio;
  } record_t;

endpackage

// ===== hdl/flvp_core.sv =====
// Byte-wide FLV parse state and record generation.
module flvp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             report_audio,
  output logic             emit,
  output flvp_pkg::record_t rec
);
  import flvp_pkg::*;

  phase_t      phase, phase_next;
  logic [23:0] field_count, field_count_next;
  logic [31:0] byte_position;
  logic [31:0] tag_start, tag_start_next;
  logic [31:0] shift_word, shift_word_next;
  logic [31:0] held_prev_size, held_prev_size_next;
  logic [7:0]  held_type_byte, held_type_byte_next;
  logic [23:0] held_size, held_size_next;
  logic [23:0] held_stamp, held_stamp_next;
  logic [7:0]  held_stamp_ext, held_stamp_ext_next;
  logic [15:0] held_version_flags, held_version_flags_next;

  phase_t      cur_phase;
  logic [23:0] cnt;
  logic [31:0] pos;
  logic [31:0] sw;
  logic [4:0]  ttype;

  always_comb begin
    cur_phase = first_byte ? PH_HEADER : phase;
    cnt       = first_byte ? 24'd0 : field_count;
    pos       = first_byte ? 32'd0 : byte_position;
    sw        = first_byte ? 32'd0 : shift_word;
    ttype     = held_type_byte[4:0] & TYPE_MASK[4:0];

    phase_next              = cur_phase;
    field_count_next        = cnt + 24'd1;
    tag_start_next          = tag_start;
    shift_word_next         = sw;
    held_prev_size_next     = held_prev_size;
    held_type_byte_next     = held_type_byte;
    held_size_next          = held_size;
    held_stamp_next         = held_stamp;
    held_stamp_ext_next     = held_stamp_ext;
    held_version_flags_next = held_version_flags;
    emit                    = 1'b0;
    rec                     = '0;

    case (cur_phase)
      PH_TAGHDR: begin
        shift_word_next = {sw[23:0], data_byte};
        if (cnt == TAG_PREV_IDX) held_prev_size_next = shift_word_next;
        if (cnt == TAG_TYPE_IDX) begin
          held_type_byte_next = data_byte;
          tag_start_next      = pos;
        end
        if (cnt == TAG_SIZE_IDX)  held_size_next      = shift_word_next[23:0];
        if (cnt == TAG_STAMP_IDX) held_stamp_next     = shift_word_next[23:0];
        if (cnt == TAG_EXT_IDX)   held_stamp_ext_next = data_byte;
        if (cnt >= TAG_LAST_IDX) begin
          emit = (ttype == TYPE_SCRIPT) || (ttype == TYPE_VIDEO) ||
                 ((ttype == TYPE_AUDIO) && report_audio);
          rec.record_kind    = REC_TAG;
          rec.type_code      = ttype;
          rec.filter_bit     = held_type_byte[5];
          rec.payload_len    = held_size;
          rec.time_stamp     = held_stamp;
          rec.time_stamp_ext = held_stamp_ext;
          rec.stream_ident   = shift_word_next[23:0];
          rec.prev_tag_size  = held_prev_size;
          rec.position       = tag_start;
          if (held_size != 24'd0) begin
            field_count_next = held_size;
            phase_next       = PH_PAYLOAD;
          end else begin
            field_count_next = 24'd0;
          end
        end
      end
      PH_PAYLOAD: begin
        if (cnt <= 24'd1) begin
          field_count_next = 24'd0;
          phase_next       = PH_TAGHDR;
        end else begin
          field_count_next = cnt - 24'd1;
        end
      end
      default: begin
        // unused codes behave as the file header phase
        phase_next      = PH_HEADER;
        shift_word_next = {sw[23:0], data_byte};
        if (cnt == HDR_VER_IDX)
          held_version_flags_next = {data_byte, held_version_flags[7:0]};
        if (cnt == HDR_FLAGS_IDX)
          held_version_flags_next = {held_version_flags[15:8], data_byte};
        if (cnt >= HDR_LAST_IDX) begin
          emit             = 1'b1;
          rec.record_kind  = REC_FILE_HDR;
          rec.position     = shift_word_next;
          rec.version      = held_version_flags[15:8];
          rec.has_video    = held_version_flags[0];
          rec.has_audio    = held_version_flags[2];
          phase_next       = PH_TAGHDR;
          field_count_next = 24'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      field_count        <= '0;
      byte_position      <= '0;
      tag_start          <= '0;
      shift_word         <= '0;
      held_prev_size     <= '0;
      held_type_byte     <= '0;
      held_size          <= '0;
      held_stamp         <= '0;
      held_stamp_ext     <= '0;
      held_version_flags <= '0;
    end else if (step) begin
      phase              <= phase_next;
      field_count        <= field_count_next;
      byte_position      <= pos + 32'd1;
      tag_start          <= tag_start_next;
      shift_word         <= shift_word_next;
      held_prev_size     <= held_prev_size_next;
      held_type_byte     <= held_type_byte_next;
      held_size          <= held_size_next;
      held_stamp         <= held_stamp_next;
      held_stamp_ext     <= held_stamp_ext_next;
      held_version_flags <= held_version_flags_next;
    end
  end

endmodule

// ===== hdl/flv_tag_header_parser_unit.sv =====
// Top level of the FLV tag header parser: stream ports, config register, result register.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_tvalid / s_tready     tdata: byte, tuser: start of file
//  m_axis    out  m_tvalid / m_tready     tdata: record fields, tuser: record kind
//  cfg       in   cfg_valid / cfg_ready   cfg_data: report_audio
//
// One byte per cycle while s_tready is high; the parse state advances on the
// accepting edge and a record appears on m_axis the following cycle.
// s_tready drops only while a record sits in the result register and m_tready is low.
// rst is synchronous and clears the parse state, the result valid and report_audio.
// cfg_ready is always high.
module flv_tag_header_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [7:0] data_byte
  input  logic                          s_tuser,  // [0] first_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [flvp_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tdata: [4:0] type_code, [5] filter_bit, [29:6] payload_len,
  // [53:30] time_stamp, [61:54] time_stamp_ext, [85:62] stream_ident,
  // [117:86] prev_tag_size, [149:118] position, [157:150] version,
  // [158] has_video, [159] has_audio
  output logic                          m_tuser,  // [0] record_kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data  // [0] report_audio
);
  import flvp_pkg::*;

  logic    report_audio;
  logic    step;
  logic    emit;
  record_t rec;
  record_t out_rec;
  logic    out_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !out_valid || m_tready;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_audio <= 1'b0;
    end else if (cfg_valid) begin
      report_audio <= cfg_data;
    end
  end

  flvp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (s_tdata),
    .first_byte   (s_tuser),
    .report_audio (report_audio),
    .emit         (emit),
    .rec          (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_rec <= rec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_rec.record_kind;
  assign m_tdata  = {out_rec.has_audio, out_rec.has_video, out_rec.version,
                     out_rec.position, out_rec.prev_tag_size, out_rec.stream_ident,
                     out_rec.time_stamp_ext, out_rec.time_stamp, out_rec.payload_len,
                     out_rec.filter_bit, out_rec.type_code};

endmodule
